// ----- rtl/bacq_pkg.sv -----
`default_nettype none

package bacq_pkg;

  localparam int unsigned ID_W        = 32;
  localparam int unsigned CNT_W       = 8;
  localparam int unsigned IDX_W       = 64;
  localparam int unsigned KIND_W      = 3;
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned NRET_W      = $clog2(MAX_RESULTS + 1);
  localparam int unsigned PADDR_W     = 3;
  localparam int unsigned PDATA_W     = 32;

  // operation codes
  localparam logic OP_SAVE = 1'b0;
  localparam logic OP_ACK  = 1'b1;

  // register map (byte addresses)
  localparam logic [PADDR_W-1:0] ADDR_TRACK_EN = 3'h0;

  typedef enum logic [KIND_W-1:0] {
    KIND_SAVED   = 3'd0,
    KIND_RENUM   = 3'd1,
    KIND_CLEARED = 3'd2,
    KIND_NONE    = 3'd3,
    KIND_FULL    = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SINGLE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_RET_RD,
    ST_RET_CMP,
    ST_RET_END
  } state_e;

  typedef struct packed {
    logic capture;     // latch input transaction
    logic start;       // clear scan and retire bookkeeping
    logic single;      // save or rejected op: update state, emit one result
    logic srch_issue;  // read slot head+scan
    logic srch_step;   // advance scan
    logic dec_write;   // decrement pending at matched slot
    logic ret_issue;   // read head slot
    logic ret_take;    // retire head into holding register
    logic ret_end;     // emit final result of an ack
  } ctrl_cmd_t;

  typedef struct packed {
    logic op_ack;
    logic enabled;
    logic out_free;
    logic srch_done;
    logic match;
    logic ret_stop;
    logic head_done;
    logic held_valid;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- rtl/bacq_ram.sv -----
`default_nettype none

module bacq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/bacq_ctrl.sv -----
`default_nettype none

module bacq_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire bacq_pkg::dp_status_t   status_i,
  output bacq_pkg::ctrl_cmd_t         cmd_o
);

  import bacq_pkg::*;

  state_e state_q, state_d;
  logic   take_ok;

  // head entry can move into the holding register once any older held one can leave
  assign take_ok = status_i.head_done && (!status_i.held_valid || status_i.out_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        if (status_i.enabled && status_i.op_ack) state_d = ST_SRCH_RD;
        else                                     state_d = ST_SINGLE;
      end
      ST_SINGLE: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      ST_SRCH_RD: begin
        if (status_i.srch_done) state_d = ST_RET_RD;
        else                    state_d = ST_SRCH_CMP;
      end
      ST_SRCH_CMP: begin
        if (status_i.match) state_d = ST_RET_RD;
        else                state_d = ST_SRCH_RD;
      end
      ST_RET_RD: begin
        if (status_i.ret_stop) state_d = ST_RET_END;
        else                   state_d = ST_RET_CMP;
      end
      ST_RET_CMP: begin
        if (!status_i.head_done) state_d = ST_RET_END;
        else if (take_ok)        state_d = ST_RET_RD;
      end
      ST_RET_END: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_DISPATCH: cmd_o.start      = 1'b1;
      ST_SINGLE:   cmd_o.single     = status_i.out_free;
      ST_SRCH_RD:  cmd_o.srch_issue = !status_i.srch_done;
      ST_SRCH_CMP: begin
        cmd_o.dec_write = status_i.match;
        cmd_o.srch_step = !status_i.match;
      end
      ST_RET_RD:   cmd_o.ret_issue  = !status_i.ret_stop;
      ST_RET_CMP:  cmd_o.ret_take   = take_ok;
      ST_RET_END:  cmd_o.ret_end    = status_i.out_free;
      default: begin
        cmd_o      = '0;
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/bacq_dp.sv -----
`default_nettype none

module bacq_dp #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          tracking_enable_i,
  input  wire bacq_pkg::ctrl_cmd_t           cmd_i,
  output bacq_pkg::dp_status_t               status_o,
  input  wire logic                          operation_i,
  input  wire logic [bacq_pkg::ID_W-1:0]     ack_batch_id_i,
  input  wire logic [bacq_pkg::CNT_W-1:0]    ack_count_i,
  input  wire logic                          dedup_mode_i,
  input  wire logic                          source_empty_i,
  input  wire logic [bacq_pkg::IDX_W-1:0]    log_index_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [bacq_pkg::KIND_W-1:0]   kind_o,
  output logic      [bacq_pkg::ID_W-1:0]     batch_number_o,
  output logic      [bacq_pkg::IDX_W-1:0]    clear_index_o,
  output logic                               last_o
);

  import bacq_pkg::*;

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SW = AW + 2;

  // captured transaction
  logic             op_q;
  logic [ID_W-1:0]  ack_id_q;
  logic [CNT_W-1:0] cnt_q;
  logic             dedup_q;
  logic             empty_q;
  logic [IDX_W-1:0] idx_q;

  // queue control
  logic [AW-1:0]     head_q, head_d, tail_q, tail_d, slot_q, slot_d;
  logic [CW-1:0]     occ_q, occ_d, scan_q, scan_d;
  logic [ID_W-1:0]   next_id_q, next_id_d;
  logic [IDX_W-1:0]  last_saved_q, last_saved_d;
  logic [NRET_W-1:0] nret_q, nret_d;
  logic              held_valid_q, held_valid_d;
  logic [ID_W-1:0]   held_id_q;
  logic [IDX_W-1:0]  held_idx_q;

  // output register
  logic             out_valid_q, out_valid_d, out_load;
  kind_e            out_kind_q, out_kind_d;
  logic [ID_W-1:0]  out_num_q, out_num_d;
  logic [IDX_W-1:0] out_idx_q, out_idx_d;
  logic             out_last_q, out_last_d;

  // memory ports
  logic             id_we, idx_we, pend_we;
  logic [AW-1:0]    id_waddr, pend_waddr;
  logic [CNT_W-1:0] pend_wdata;
  logic [ID_W-1:0]  rd_id;
  logic [IDX_W-1:0] rd_idx;
  logic [CNT_W-1:0] rd_pend;

  logic             out_free, is_save, renum, full;
  logic [AW-1:0]    head_inc, tail_inc, tail_dec, scan_slot;
  logic [SW-1:0]    scan_sum;
  logic [IDX_W-1:0] new_idx;
  kind_e            single_kind;

  assign out_free = !out_valid_q || out_ready_i;
  assign is_save  = tracking_enable_i && (op_q == OP_SAVE);
  assign renum    = !dedup_q && (idx_q == last_saved_q);
  assign full     = (occ_q == CW'(QUEUE_DEPTH));
  assign new_idx  = (dedup_q && !empty_q) ? idx_q - IDX_W'(1) : idx_q;

  assign head_inc = (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign tail_inc = (tail_q == AW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
  assign tail_dec = (tail_q == '0) ? AW'(QUEUE_DEPTH - 1) : tail_q - 1'b1;

  // head + scan stays below twice the depth
  assign scan_sum  = SW'(head_q) + SW'(scan_q);
  assign scan_slot = (scan_sum >= SW'(QUEUE_DEPTH)) ? AW'(scan_sum - SW'(QUEUE_DEPTH))
                                                    : AW'(scan_sum);

  always_comb begin
    if (!tracking_enable_i || op_q == OP_ACK) single_kind = KIND_FULL;
    else if (renum)                           single_kind = KIND_RENUM;
    else if (full)                            single_kind = KIND_FULL;
    else                                      single_kind = KIND_SAVED;
  end

  // queue state and memory writes
  always_comb begin
    head_d       = head_q;
    tail_d       = tail_q;
    occ_d        = occ_q;
    next_id_d    = next_id_q;
    last_saved_d = last_saved_q;
    scan_d       = scan_q;
    nret_d       = nret_q;
    slot_d       = slot_q;
    held_valid_d = held_valid_q;
    id_we        = 1'b0;
    idx_we       = 1'b0;
    pend_we      = 1'b0;
    id_waddr     = tail_q;
    pend_waddr   = tail_q;
    pend_wdata   = cnt_q;

    if (cmd_i.start) begin
      scan_d       = '0;
      nret_d       = '0;
      held_valid_d = 1'b0;
    end
    if (cmd_i.single && is_save) begin
      if (renum) begin
        next_id_d = next_id_q + 1'b1;
        if (occ_q != '0) begin
          id_we    = 1'b1;
          id_waddr = tail_dec;
        end
      end else if (!full) begin
        id_we        = 1'b1;
        idx_we       = 1'b1;
        pend_we      = 1'b1;
        tail_d       = tail_inc;
        occ_d        = occ_q + 1'b1;
        next_id_d    = next_id_q + 1'b1;
        last_saved_d = idx_q;
      end
    end
    if (cmd_i.srch_issue) slot_d = scan_slot;
    if (cmd_i.srch_step)  scan_d = scan_q + 1'b1;
    if (cmd_i.dec_write) begin
      pend_we    = 1'b1;
      pend_waddr = slot_q;
      pend_wdata = rd_pend - 1'b1;
    end
    if (cmd_i.ret_issue) slot_d = head_q;
    if (cmd_i.ret_take) begin
      head_d       = head_inc;
      occ_d        = occ_q - 1'b1;
      nret_d       = nret_q + 1'b1;
      held_valid_d = 1'b1;
    end
    if (cmd_i.ret_end) held_valid_d = 1'b0;
  end

  // result register loads
  always_comb begin
    out_load   = 1'b0;
    out_kind_d = out_kind_q;
    out_num_d  = out_num_q;
    out_idx_d  = out_idx_q;
    out_last_d = out_last_q;
    if (cmd_i.single) begin
      out_load   = 1'b1;
      out_kind_d = single_kind;
      out_num_d  = (single_kind == KIND_FULL) ? '0 : next_id_q;
      out_idx_d  = '0;
      out_last_d = 1'b1;
    end else if ((cmd_i.ret_take && held_valid_q) || cmd_i.ret_end) begin
      out_load   = 1'b1;
      out_kind_d = held_valid_q ? KIND_CLEARED : KIND_NONE;
      out_num_d  = held_valid_q ? held_id_q : '0;
      out_idx_d  = held_valid_q ? held_idx_q : '0;
      out_last_d = cmd_i.ret_end;
    end
    if (out_load)         out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
    else                  out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q       <= '0;
      tail_q       <= '0;
      occ_q        <= '0;
      next_id_q    <= '0;
      last_saved_q <= '0;
      scan_q       <= '0;
      nret_q       <= '0;
      slot_q       <= '0;
      held_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      head_q       <= head_d;
      tail_q       <= tail_d;
      occ_q        <= occ_d;
      next_id_q    <= next_id_d;
      last_saved_q <= last_saved_d;
      scan_q       <= scan_d;
      nret_q       <= nret_d;
      slot_q       <= slot_d;
      held_valid_q <= held_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q     <= operation_i;
      ack_id_q <= ack_batch_id_i;
      cnt_q    <= ack_count_i;
      dedup_q  <= dedup_mode_i;
      empty_q  <= source_empty_i;
      idx_q    <= log_index_i;
    end
    if (cmd_i.ret_take) begin
      held_id_q  <= rd_id;
      held_idx_q <= rd_idx;
    end
    out_kind_q <= out_kind_d;
    out_num_q  <= out_num_d;
    out_idx_q  <= out_idx_d;
    out_last_q <= out_last_d;
  end

  // read address follows slot_d so data for slot_q is ready while slot_q holds it
  bacq_ram #(.WIDTH(ID_W), .DEPTH(QUEUE_DEPTH)) u_id_ram (
    .clk_i   (clk_i),
    .we_i    (id_we),
    .waddr_i (id_waddr),
    .wdata_i (next_id_q),
    .raddr_i (slot_d),
    .rdata_o (rd_id)
  );

  bacq_ram #(.WIDTH(IDX_W), .DEPTH(QUEUE_DEPTH)) u_idx_ram (
    .clk_i   (clk_i),
    .we_i    (idx_we),
    .waddr_i (tail_q),
    .wdata_i (new_idx),
    .raddr_i (slot_d),
    .rdata_o (rd_idx)
  );

  bacq_ram #(.WIDTH(CNT_W), .DEPTH(QUEUE_DEPTH)) u_pend_ram (
    .clk_i   (clk_i),
    .we_i    (pend_we),
    .waddr_i (pend_waddr),
    .wdata_i (pend_wdata),
    .raddr_i (slot_d),
    .rdata_o (rd_pend)
  );

  assign status_o.op_ack     = (op_q == OP_ACK);
  assign status_o.enabled    = tracking_enable_i;
  assign status_o.out_free   = out_free;
  assign status_o.srch_done  = (scan_q == occ_q);
  assign status_o.match      = (rd_id == ack_id_q) && (rd_pend != '0);
  assign status_o.ret_stop   = (occ_q == '0) || (nret_q == NRET_W'(MAX_RESULTS));
  assign status_o.head_done  = (rd_pend == '0);
  assign status_o.held_valid = held_valid_q;

  assign out_valid_o    = out_valid_q;
  assign kind_o         = KIND_W'(out_kind_q);
  assign batch_number_o = out_num_q;
  assign clear_index_o  = out_idx_q;
  assign last_o         = out_last_q;

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CW'(QUEUE_DEPTH))
    else $error("occupancy above depth");

  a_ptr_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q == tail_q) |-> (occ_q == '0 || occ_q == CW'(QUEUE_DEPTH)))
    else $error("pointers disagree with occupancy");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten before transfer");

  a_nret_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nret_q <= NRET_W'(MAX_RESULTS))
    else $error("retire count above limit");

  a_take_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ret_take |=> held_valid_q)
    else $error("retired entry not held");

endmodule

`default_nettype wire

// ----- rtl/batch_ack_retire_queue_core.sv -----
// Save, or any transaction while tracking is disabled: goes from dispatch to a single result
//   state, which waits for a free result register, loads the result and returns to idle.
// Ack: scans entries from the head up to the match, then retires finished head entries
//   (at most 16); the single read port of the entry memories serializes scan and retire.
// Reset (rst_ni, async, active low) empties the queue, zeroes the id counter and last saved
//   index and disables tracking; entry memories are not cleared and need no clearing pass.
`default_nettype none

module batch_ack_retire_queue_core #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // input transactions
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic                                operation_i,
  input  wire logic [bacq_pkg::ID_W-1:0]           ack_batch_id_i,
  input  wire logic [bacq_pkg::CNT_W-1:0]          ack_count_i,
  input  wire logic                                dedup_mode_i,
  input  wire logic                                source_empty_i,
  input  wire logic [bacq_pkg::IDX_W-1:0]          log_index_i,
  // result transactions
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic      [bacq_pkg::KIND_W-1:0]         kind_o,
  output logic      [bacq_pkg::ID_W-1:0]           batch_number_o,
  output logic      [bacq_pkg::IDX_W-1:0]          clear_index_o,
  output logic                                     last_o,
  // APB-style configuration
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [bacq_pkg::PADDR_W-1:0]        paddr,
  input  wire logic [bacq_pkg::PDATA_W-1:0]        pwdata,
  output logic      [bacq_pkg::PDATA_W-1:0]        prdata,
  output logic                                     pready
);

  import bacq_pkg::*;

  // Only one register: tracking_enable at byte address 0. Writes land in the
  // access phase; no wait states. Other addresses read as zero and ignore writes.
  logic       track_en_q;
  logic       cfg_wr;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      track_en_q <= 1'b0;
    end else if (cfg_wr && paddr == ADDR_TRACK_EN) begin
      track_en_q <= pwdata[0];
    end
  end

  assign prdata = (paddr == ADDR_TRACK_EN) ? PDATA_W'(track_en_q) : '0;

  // Controller walks save / scan / retire phases; the datapath holds the
  // queue pointers, the entry memories, the retire holding register and the
  // result register. A retired entry is held back one step so its "last"
  // flag is known before it is sent: the final one goes out when the scan of
  // the head stops (unfinished entry, empty queue, or 16 per ack).
  bacq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bacq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .tracking_enable_i (track_en_q),
    .cmd_i             (cmd),
    .status_o          (status),
    .operation_i       (operation_i),
    .ack_batch_id_i    (ack_batch_id_i),
    .ack_count_i       (ack_count_i),
    .dedup_mode_i      (dedup_mode_i),
    .source_empty_i    (source_empty_i),
    .log_index_i       (log_index_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .kind_o            (kind_o),
    .batch_number_o    (batch_number_o),
    .clear_index_o     (clear_index_o),
    .last_o            (last_o)
  );

  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.capture) |=> !in_ready_o)
    else $error("input taken while a transaction is in progress");

endmodule

`default_nettype wire
